[src/frx_pkg.sv]
// ----------------------------------------------------------------------------
// frx_pkg
// Shared types and constants for the fixed-length frame receiver.
// ----------------------------------------------------------------------------
package frx_pkg;

  localparam int FRAME_DEPTH = 64;
  localparam int ADDR_W      = $clog2(FRAME_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 7;
  localparam int POS_W       = 6;
  localparam int CMP_W       = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SYNC  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_SYNC = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LEN   = 2'd2;

  localparam logic [BYTE_W-1:0] FIRST_SYNC_RST  = 8'd170;
  localparam logic [BYTE_W-1:0] SECOND_SYNC_RST = 8'd85;
  localparam logic [LEN_W-1:0]  FRAME_LEN_RST   = 7'd16;

  typedef enum logic [2:0] {
    ST_SYNC1,
    ST_SYNC2,
    ST_BODY,
    ST_CHECK,
    ST_READ,
    ST_LOAD
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic start_frame;
    logic take_sync2;
    logic take_body;
    logic take_check;
    logic rd_issue;
    logic load_out;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_sync1;
    logic is_sync2;
    logic overrun;
    logic body_done;
    logic sum_match;
    logic no_emit;
    logic emit_last;
    logic out_free;
  } status_t;

endpackage

[src/fixed_length_frame_receiver.sv]
// ----------------------------------------------------------------------------
// fixed_length_frame_receiver
// Preamble-synchronized fixed-length frame receiver with additive checksum.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_rx_byte) takes one received byte
//   per word. While parsing, in_stall is low and a byte is taken every cycle.
//   The block hunts for the first and second sync bytes, then stores bytes up
//   to the configured frame length, the last being an 8-bit wrapping sum of
//   all bytes before it.
//   On a checksum match the stored frame is replayed on the output channel
//   (out_valid / out_stall / out_frame_byte, out_byte_position,
//   out_last_byte), last byte flagged. On a mismatch, or with a zero length, nothing is sent.
//   Replay: after the checksum byte is taken, each word takes one frame-store
//   read and then one output register load before the next word's read starts.
//   in_stall stays high during replay and drops as the last word is loaded.
//   A stall on the output holds the current word and pauses the replay.
//   Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) is always
//   ready; index 0 first sync, 1 second sync, 2 frame length, others ignored.
//   Reset (rst_n low, synchronous) restores default sync bytes and length,
//   restarts the hunt and drops any pending output word.
// ----------------------------------------------------------------------------
module fixed_length_frame_receiver (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [frx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [frx_pkg::BYTE_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [frx_pkg::BYTE_W-1:0]     in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [frx_pkg::BYTE_W-1:0]     out_frame_byte,
  output logic [frx_pkg::POS_W-1:0]      out_byte_position,
  output logic                           out_last_byte
);

  import frx_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer: decides which byte role is taken and drives the replay
  frx_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // storage, sum, compares and the output register
  frx_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_frame_byte    (out_frame_byte),
    .out_byte_position (out_byte_position),
    .out_last_byte     (out_last_byte),
    .cmd               (cmd),
    .status            (status)
  );

endmodule

[src/frx_ram.sv]
// ----------------------------------------------------------------------------
// frx_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module frx_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/frx_ctrl.sv]
// ----------------------------------------------------------------------------
// frx_ctrl
// Parse and replay sequencer: preamble hunt, body capture, checksum test,
// then one RAM read and one output load per emitted word.
// ----------------------------------------------------------------------------
module frx_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  frx_pkg::status_t  status,
  output frx_pkg::cmd_t     cmd
);

  import frx_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   in_fire;

  assign in_fire = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SYNC1;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_SYNC1: begin
        if (in_fire && status.is_sync1) begin
          state_nxt = ST_SYNC2;
        end
      end
      ST_SYNC2: begin
        if (in_fire) begin
          state_nxt = status.is_sync2 ? ST_BODY : ST_SYNC1;
        end
      end
      ST_BODY: begin
        if (in_fire) begin
          if (status.overrun) begin
            state_nxt = ST_SYNC1;
          end else if (status.body_done) begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (in_fire) begin
          state_nxt = (status.sum_match && !status.no_emit) ? ST_READ : ST_SYNC1;
        end
      end
      ST_READ: begin
        if (status.out_free) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_nxt = status.emit_last ? ST_SYNC1 : ST_READ;
      end
      default: state_nxt = ST_SYNC1;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    cmd      = '0;
    unique case (state_r)
      ST_SYNC1: begin
        in_stall        = 1'b0;
        cmd.start_frame = in_fire;
      end
      ST_SYNC2: begin
        in_stall       = 1'b0;
        cmd.take_sync2 = in_fire && status.is_sync2;
      end
      ST_BODY: begin
        in_stall      = 1'b0;
        cmd.take_body = in_fire && !status.overrun;
      end
      ST_CHECK: begin
        in_stall       = 1'b0;
        cmd.take_check = in_fire;
      end
      ST_READ: begin
        cmd.rd_issue = status.out_free;
      end
      ST_LOAD: begin
        cmd.load_out = 1'b1;
      end
      default: in_stall = 1'b1;
    endcase
  end

endmodule

[src/frx_dp.sv]
// ----------------------------------------------------------------------------
// frx_dp
// Datapath: configuration registers, write pointer, running sum, frame
// store and the output word register.
// ----------------------------------------------------------------------------
module frx_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [frx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [frx_pkg::BYTE_W-1:0]     cfg_data,
  input  logic [frx_pkg::BYTE_W-1:0]     in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [frx_pkg::BYTE_W-1:0]     out_frame_byte,
  output logic [frx_pkg::POS_W-1:0]      out_byte_position,
  output logic                           out_last_byte,
  input  frx_pkg::cmd_t                  cmd,
  output frx_pkg::status_t               status
);

  import frx_pkg::*;

  logic [BYTE_W-1:0] sync1_r, sync1_nxt;
  logic [BYTE_W-1:0] sync2_r, sync2_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [ADDR_W-1:0] wp_r, wp_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic              ovld_r, ovld_nxt;
  logic [BYTE_W-1:0] obyte_r, obyte_nxt;
  logic [POS_W-1:0]  opos_r, opos_nxt;
  logic              olast_r, olast_nxt;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [BYTE_W-1:0] rd_data;
  logic [CMP_W-1:0]  len_ext;
  logic [CMP_W-1:0]  wp_ext;
  logic [CMP_W-1:0]  idx_ext;
  logic [CMP_W-1:0]  depth_ext;

  assign cfg_ready = 1'b1;

  assign len_ext   = CMP_W'(len_r);
  assign wp_ext    = CMP_W'(wp_r);
  assign idx_ext   = CMP_W'(idx_r);
  assign depth_ext = CMP_W'(FRAME_DEPTH);

  assign status.is_sync1  = (in_rx_byte == sync1_r);
  assign status.is_sync2  = (in_rx_byte == sync2_r);
  assign status.overrun   = (wp_r == ADDR_W'(FRAME_DEPTH - 1));
  // pointer after this byte, plus one, reaches the configured length
  assign status.body_done = ((wp_ext + CMP_W'(2)) >= len_ext);
  assign status.sum_match = (in_rx_byte == sum_r);
  assign status.no_emit   = (len_r == '0);
  assign status.emit_last = (({1'b0, idx_r} + CNT_W'(1)) == n_r);
  assign status.out_free  = !ovld_r || !out_stall;

  assign wr_en   = cmd.start_frame || cmd.take_sync2 || cmd.take_body || cmd.take_check;
  assign wr_addr = cmd.start_frame ? '0 : (cmd.take_sync2 ? ADDR_W'(1) : wp_r);

  frx_ram #(
    .Width (BYTE_W),
    .Depth (FRAME_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_rx_byte),
    .rd_en   (cmd.rd_issue),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  always_comb begin
    sync1_nxt = sync1_r;
    sync2_nxt = sync2_r;
    len_nxt   = len_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FIRST_SYNC:  sync1_nxt = cfg_data;
        CFG_SECOND_SYNC: sync2_nxt = cfg_data;
        CFG_FRAME_LEN:   len_nxt   = cfg_data[LEN_W-1:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    wp_nxt    = wp_r;
    sum_nxt   = sum_r;
    n_nxt     = n_r;
    idx_nxt   = idx_r;
    ovld_nxt  = ovld_r && out_stall;
    obyte_nxt = obyte_r;
    opos_nxt  = opos_r;
    olast_nxt = olast_r;
    if (cmd.start_frame) begin
      wp_nxt  = '0;
      sum_nxt = in_rx_byte;
    end
    if (cmd.take_sync2) begin
      wp_nxt  = ADDR_W'(2);
      sum_nxt = sum_r + in_rx_byte;
    end
    if (cmd.take_body) begin
      wp_nxt  = wp_r + ADDR_W'(1);
      sum_nxt = sum_r + in_rx_byte;
    end
    if (cmd.take_check) begin
      // clamp the replay count to the store depth
      n_nxt   = (len_ext > depth_ext) ? CNT_W'(FRAME_DEPTH) : CNT_W'(len_ext);
      idx_nxt = '0;
    end
    if (cmd.load_out) begin
      ovld_nxt  = 1'b1;
      obyte_nxt = rd_data;
      opos_nxt  = idx_ext[POS_W-1:0];
      olast_nxt = ((idx_ext + CMP_W'(1)) == len_ext);
      idx_nxt   = idx_r + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync1_r <= FIRST_SYNC_RST;
      sync2_r <= SECOND_SYNC_RST;
      len_r   <= FRAME_LEN_RST;
      wp_r    <= '0;
      sum_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      sync1_r <= sync1_nxt;
      sync2_r <= sync2_nxt;
      len_r   <= len_nxt;
      wp_r    <= wp_nxt;
      sum_r   <= sum_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    idx_r   <= idx_nxt;
    obyte_r <= obyte_nxt;
    opos_r  <= opos_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid         = ovld_r;
  assign out_frame_byte    = obyte_r;
  assign out_byte_position = opos_r;
  assign out_last_byte     = olast_r;

endmodule

[src/frx_checker.sv]
// ----------------------------------------------------------------------------
// frx_checker
// Port-level checks for the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module frx_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_stall,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [frx_pkg::BYTE_W-1:0]     out_frame_byte,
  input  logic [frx_pkg::POS_W-1:0]      out_byte_position,
  input  logic                           out_last_byte
);

  // reset drops any pending output word
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output word survived reset");

  // a stalled word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped under stall");

  // a stalled word keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_frame_byte) && $stable(out_byte_position)
                               && $stable(out_last_byte))
    else $error("output payload changed under stall");

  // a word from the middle of a replay holds off new input
  a_mid_replay_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_byte |-> in_stall)
    else $error("input taken while a replay is in progress");

endmodule

bind fixed_length_frame_receiver frx_checker u_frx_checker (.*);

[tb/tb_fixed_length_frame_receiver.sv]
// ----------------------------------------------------------------------------
// tb_fixed_length_frame_receiver
// Self-checking bench for the preamble-synchronized frame receiver: a
// scoreboard class tracks the parser state byte by byte and queues the frame
// words that a checksum match must replay. Directed frames cover the sync
// extremes, bad preambles, bad checksums and short lengths. Random phases then
// sweep several register settings, including the longest frame and an overrun.
// ----------------------------------------------------------------------------
module tb_fixed_length_frame_receiver;
  import frx_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 2 * FRAME_DEPTH + 16;
  localparam int DRAIN_LIMIT   = 20000;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [POS_W-1:0]  pos;
    logic              is_last;
  } replay_word_t;

  // Track the parser and hold the words that the next replay must show.
  class frame_replay_tracker;
    logic [BYTE_W-1:0] sync_a;
    logic [BYTE_W-1:0] sync_b;
    logic [LEN_W-1:0]  len;
    state_t            phase;
    int unsigned       wr_pos;
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] store [FRAME_DEPTH];
    replay_word_t      replay_words [$];
    int                errors;

    function new();
      sync_a = FIRST_SYNC_RST;
      sync_b = SECOND_SYNC_RST;
      len    = FRAME_LEN_RST;
      phase  = ST_SYNC1;
      wr_pos = 0;
      sum    = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] value);
      case (idx)
        CFG_FIRST_SYNC:  sync_a = value;
        CFG_SECOND_SYNC: sync_b = value;
        CFG_FRAME_LEN:   len    = value[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_rx_byte(logic [BYTE_W-1:0] b);
      int unsigned  n;
      int unsigned  i;
      replay_word_t w;
      case (phase)
        ST_SYNC1: begin
          wr_pos   = 0;
          sum      = b;
          store[0] = b;
          if (b == sync_a) phase = ST_SYNC2;
        end
        ST_SYNC2: begin
          if (b == sync_b) begin
            wr_pos   = 2;
            sum      = sum + b;
            store[1] = b;
            phase    = ST_BODY;
          end else begin
            phase = ST_SYNC1;
          end
        end
        ST_BODY: begin
          if (wr_pos >= FRAME_DEPTH - 1) begin
            phase = ST_SYNC1;
          end else begin
            store[wr_pos] = b;
            wr_pos++;
            sum = sum + b;
            if (int'(wr_pos) >= int'(len) - 1) phase = ST_CHECK;
          end
        end
        default: begin
          if (wr_pos < FRAME_DEPTH) store[wr_pos] = b;
          phase = ST_SYNC1;
          if (sum == b) begin
            n = (len > FRAME_DEPTH) ? FRAME_DEPTH : len;
            for (i = 0; i < n; i++) begin
              w.data    = store[i];
              w.pos     = i[POS_W-1:0];
              w.is_last = (i + 1 == len);
              replay_words.push_back(w);
            end
          end
        end
      endcase
    endfunction

    function void flag(string what, replay_word_t want, replay_word_t got);
      errors++;
      if (errors <= 10)
        $display("%s: expected byte %02h pos %0d last %0b, got byte %02h pos %0d last %0b",
                 what, want.data, want.pos, want.is_last, got.data, got.pos, got.is_last);
    endfunction

    function void check_replay_word(replay_word_t got);
      replay_word_t want;
      if (replay_words.size() == 0) begin
        flag("unexpected word", '0, got);
      end else begin
        want = replay_words.pop_front();
        if (got.data !== want.data || got.pos !== want.pos || got.is_last !== want.is_last)
          flag("word mismatch", want, got);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_FIRST_SYNC;
  logic [BYTE_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [BYTE_W-1:0]    in_rx_byte = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [BYTE_W-1:0]    out_frame_byte;
  logic [POS_W-1:0]     out_byte_position;
  logic                 out_last_byte;

  frame_replay_tracker sb = new();
  bit gaps_on = 1'b1;
  int items_sent = 0;

  fixed_length_frame_receiver DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_frame_byte    (out_frame_byte),
    .out_byte_position (out_byte_position),
    .out_last_byte     (out_last_byte)
  );

  always #5 clk = ~clk;

  // Check every word taken at this edge, then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_replay_word('{out_frame_byte, out_byte_position, out_last_byte});
    out_stall <= gaps_on && ($urandom_range(0, 99) < 20);
  end

  // Offer one byte, hold it until taken, and note it in the tracker.
  task automatic send_byte(logic [BYTE_W-1:0] b);
    if (gaps_on && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_rx_byte(b);
    items_sent++;
  endtask

  // Leave valid high; the caller drops it after the last write.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  // Drop valid, wait out every pending word, then idle for the settle period.
  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (sb.replay_words.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Reprogram only while idle; poke the unused index too, which must be ignored.
  task automatic configure(logic [BYTE_W-1:0] a, logic [BYTE_W-1:0] b,
                           logic [BYTE_W-1:0] len_word);
    drain();
    cfg_write(CFG_UNUSED, 8'($urandom_range(0, 255)));
    cfg_write(CFG_FIRST_SYNC, a);
    cfg_write(CFG_SECOND_SYNC, b);
    cfg_write(CFG_FRAME_LEN, len_word);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed frames with random bodies; the rest is noise, a bad
  // second preamble or a bad checksum.
  task automatic send_random_frame();
    logic [BYTE_W-1:0] total;
    logic [BYTE_W-1:0] b;
    int                body_n;
    int                pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      send_byte(8'($urandom_range(0, 255)));
      return;
    end
    send_byte(sb.sync_a);
    if (pick < 14) begin
      b = sb.sync_b + 8'($urandom_range(1, 255));
      send_byte(b);
      return;
    end
    send_byte(sb.sync_b);
    total = sb.sync_a + sb.sync_b;
    // A length past the store depth runs into an overrun: no checksum byte.
    if (sb.len > FRAME_DEPTH) body_n = FRAME_DEPTH - 2;
    else if (sb.len < 4)      body_n = 1;
    else                      body_n = sb.len - 3;
    repeat (body_n) begin
      b = 8'($urandom_range(0, 255));
      total = total + b;
      send_byte(b);
    end
    if (sb.len > FRAME_DEPTH) return;
    if (pick < 24) total = total ^ 8'($urandom_range(1, 255));
    send_byte(total);
  endtask

  task automatic run_phase(int budget);
    int stop_at;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) send_random_frame();
  endtask

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values: 0xAA / 0x55, 16-byte frames.
    run_phase(45);

    // Sync extremes, four-byte frames.
    configure(8'hFF, 8'h00, 8'h04);
    send_byte(8'hFF); send_byte(8'h00); send_byte(8'h12); send_byte(8'h11);
    // Wrong second preamble: restart the hunt.
    send_byte(8'hFF); send_byte(8'h01);
    // The rejected second byte must not count as a new first preamble.
    send_byte(8'hFF); send_byte(8'hFF); send_byte(8'h00);
    // Bad checksum: drop the frame, then a frame with a good checksum.
    send_byte(8'hFF); send_byte(8'h00); send_byte(8'h80); send_byte(8'h00);
    send_byte(8'hFF); send_byte(8'h00); send_byte(8'h00); send_byte(8'hFF);
    // Length 1 (upper data bit set, ignored): replay only the first byte.
    configure(8'hFF, 8'h00, 8'h81);
    send_byte(8'hFF); send_byte(8'h00); send_byte(8'h7F); send_byte(8'h7E);
    // Length 0: a matching checksum replays nothing.
    configure(8'hFF, 8'h00, 8'h00);
    send_byte(8'hFF); send_byte(8'h00); send_byte(8'h01); send_byte(8'h00);

    // Long stretch without gaps or stalls.
    configure(8'h5A, 8'hA5, 8'd8);
    gaps_on = 1'b0;
    run_phase(50);
    gaps_on = 1'b1;

    configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(4, 12)));
    run_phase(50);

    // Full-depth frames.
    configure(8'h00, 8'hFF, 8'd64);
    run_phase(40);

    // Length 100: every frame overruns the store.
    configure(8'h3C, 8'hC3, 8'hE4);
    run_phase(40);

    // Equal preambles, frame length 3.
    configure(8'hFF, 8'hFF, 8'h83);
    run_phase(30);

    configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'd5);
    run_phase(30);

    drain();
    if (sb.errors == 0 && sb.replay_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
